// File: rtl/slsd_pkg.sv
// Shared types and constants for the sync-word frame deframer.
// No dependencies; used by all modules under rtl.
package slsd_pkg;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 1;
	localparam int LEN_W       = 13;

	localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_WORD = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BODY  = 1'b1;

	localparam logic [31:0]      SYNC_RESET    = 32'hFFFE_FDFC;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd4096;

	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_CHECKSUM = 2'd1;
	localparam logic [1:0] ST_BAD_SIZE = 2'd2;

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [7:0]       data_byte;
		logic [15:0]      command;
		logic [LEN_W-1:0] body_length;
		logic [1:0]       status;
		logic             frame_last;
	} res_t;

endpackage

// File: rtl/sync_length_sum_frame_deframer.sv
// Top level of the sync-word, length-prefixed frame deframer.
// Depends on slsd_pkg, slsd_parser and slsd_out_buf.
//
// Input stream s_*: one received byte per request in s_tdata.
// Output stream m_*: one request per body byte (m_tuser low) and one
// frame-end summary (m_tuser high, m_tlast high) per frame or rejected size.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 sync word, 1 max body length); write only while idle.
// The parser handles each byte combinationally; its result is registered in the
// output main stage, or in the skid stage while the receiver stalls.
// Throughput is one byte per cycle while s_tready is high; the parser state
// update sits between the input handshake and the result register.
// When the receiver stalls, one further result is held in a skid stage;
// s_tready then drops until the stalled result is taken.
// Reset clears the parser to hunting with an empty window, empties the
// output stages and restores the configuration to its defaults.
module sync_length_sum_frame_deframer #(
	parameter int MAX_BODY = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] rx_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] data_byte, [23:8] command, [36:24] body_length, [38:37] status, [39] zero
	output logic [39:0]                     m_tdata,
	output logic                            m_tuser,  // [0] kind
	output logic                            m_tlast,  // frame_last
	input  logic                            cfg_we,
	input  logic [slsd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [slsd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [31:0]                sync_word_q;
	logic [slsd_pkg::LEN_W-1:0] max_len_q;
	logic                       in_accept;
	logic                       res_valid;
	slsd_pkg::res_t             res;
	slsd_pkg::res_t             out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= slsd_pkg::SYNC_RESET;
			max_len_q   <= slsd_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slsd_pkg::CFG_SYNC_WORD: sync_word_q <= cfg_data[31:0];
				slsd_pkg::CFG_MAX_BODY:  max_len_q   <= cfg_data[slsd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_accept = s_tvalid && s_tready;

	slsd_parser #(
		.MAX_BODY(MAX_BODY)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_accept      (in_accept),
		.rx_byte        (s_tdata),
		.sync_word      (sync_word_q),
		.max_body_length(max_len_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	slsd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_accept && res_valid),
		.in_res   (res),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = {1'b0, out_res.status, out_res.body_length,
	                  out_res.command, out_res.data_byte};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.frame_last;

endmodule

// File: rtl/slsd_parser.sv
// Frame parser: sync hunt, size/command/body/checksum phases, one byte a request.
// Depends on slsd_pkg for the result type and status codes.
module slsd_parser #(
	parameter int MAX_BODY = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_accept,
	input  logic [7:0]                rx_byte,
	input  logic [31:0]               sync_word,
	input  logic [slsd_pkg::LEN_W-1:0] max_body_length,
	output logic                      res_valid,
	output slsd_pkg::res_t            res
);

	localparam int LEN_MAX   = (1 << slsd_pkg::LEN_W) - 1;
	localparam int LIMIT_CAP = (MAX_BODY < LEN_MAX) ? MAX_BODY : LEN_MAX;
	localparam int CNT_W     = $clog2(LIMIT_CAP + 1);
	localparam logic [slsd_pkg::LEN_W-1:0] CAP = slsd_pkg::LEN_W'(LIMIT_CAP);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_SIZE0 = 3'd1;
	localparam logic [2:0] PH_SIZE1 = 3'd2;
	localparam logic [2:0] PH_CMD0  = 3'd3;
	localparam logic [2:0] PH_CMD1  = 3'd4;
	localparam logic [2:0] PH_BODY  = 3'd5;
	localparam logic [2:0] PH_CHK0  = 3'd6;
	localparam logic [2:0] PH_CHK1  = 3'd7;

	logic [2:0]       phase_q, phase_d;
	logic [31:0]      window_q, window_d;
	logic [2:0]       fill_q, fill_d;
	logic [15:0]      size_q, size_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [15:0]      cmd_q, cmd_d;
	logic [15:0]      sum_q, sum_d;
	logic [7:0]       chk_lo_q, chk_lo_d;

	logic [31:0]      window_sh;
	logic [2:0]       fill_inc;
	logic [15:0]      size_full;
	logic [15:0]      size_m2;
	logic [15:0]      size_full_m2;
	logic [slsd_pkg::LEN_W-1:0] limit;
	logic [CNT_W-1:0] cnt_inc;
	logic [15:0]      sum_add;

	assign window_sh    = {rx_byte, window_q[31:8]};
	assign fill_inc     = (fill_q < 3'd4) ? fill_q + 3'd1 : fill_q;
	assign size_full    = {rx_byte, size_q[7:0]};
	assign size_full_m2 = size_full - 16'd2;
	assign size_m2      = size_q - 16'd2;
	assign limit        = (max_body_length > CAP) ? CAP : max_body_length;
	assign cnt_inc      = cnt_q + CNT_W'(1);
	assign sum_add      = sum_q + {8'd0, rx_byte};

	always_comb begin
		phase_d   = phase_q;
		window_d  = window_q;
		fill_d    = fill_q;
		size_d    = size_q;
		cnt_d     = cnt_q;
		cmd_d     = cmd_q;
		sum_d     = sum_q;
		chk_lo_d  = chk_lo_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_HUNT: begin
				window_d = window_sh;
				fill_d   = fill_inc;
				if (fill_inc == 3'd4 && window_sh == sync_word) begin
					phase_d  = PH_SIZE0;
					window_d = '0;
					fill_d   = '0;
				end
			end
			PH_SIZE0: begin
				size_d  = {8'd0, rx_byte};
				phase_d = PH_SIZE1;
			end
			PH_SIZE1: begin
				size_d = size_full;
				if (size_full < 16'd3 || size_full_m2 > {3'd0, limit}) begin
					phase_d        = PH_HUNT;
					window_d       = '0;
					fill_d         = '0;
					res_valid      = 1'b1;
					res.kind       = slsd_pkg::KIND_SUMMARY;
					res.status     = slsd_pkg::ST_BAD_SIZE;
					res.frame_last = 1'b1;
				end else begin
					phase_d = PH_CMD0;
				end
			end
			PH_CMD0: begin
				cmd_d   = {8'd0, rx_byte};
				sum_d   = {8'd0, rx_byte};
				phase_d = PH_CMD1;
			end
			PH_CMD1: begin
				cmd_d   = {rx_byte, cmd_q[7:0]};
				sum_d   = sum_add;
				cnt_d   = '0;
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				sum_d = sum_add;
				cnt_d = cnt_inc;
				// size was checked against the limit, so the count never wraps
				if ({{(16-CNT_W){1'b0}}, cnt_inc} >= size_m2)
					phase_d = PH_CHK0;
				res_valid     = 1'b1;
				res.kind      = slsd_pkg::KIND_DATA;
				res.data_byte = rx_byte;
				res.command   = cmd_q;
			end
			PH_CHK0: begin
				chk_lo_d = rx_byte;
				phase_d  = PH_CHK1;
			end
			PH_CHK1: begin
				phase_d         = PH_HUNT;
				window_d        = '0;
				fill_d          = '0;
				res_valid       = 1'b1;
				res.kind        = slsd_pkg::KIND_SUMMARY;
				res.command     = cmd_q;
				res.body_length = size_m2[slsd_pkg::LEN_W-1:0];
				res.status      = ({rx_byte, chk_lo_q} == sum_q) ?
				                  slsd_pkg::ST_GOOD : slsd_pkg::ST_CHECKSUM;
				res.frame_last  = 1'b1;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			window_q <= '0;
			fill_q   <= '0;
			size_q   <= '0;
			cnt_q    <= '0;
			cmd_q    <= '0;
			sum_q    <= '0;
			chk_lo_q <= '0;
		end else if (in_accept) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			fill_q   <= fill_d;
			size_q   <= size_d;
			cnt_q    <= cnt_d;
			cmd_q    <= cmd_d;
			sum_q    <= sum_d;
			chk_lo_q <= chk_lo_d;
		end
	end

endmodule

// File: rtl/slsd_out_buf.sv
// Result register with a one-entry skid stage between parser and output stream.
// Depends on slsd_pkg for the result type.
module slsd_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  slsd_pkg::res_t in_res,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output slsd_pkg::res_t out_res
);

	logic           main_valid_q;
	logic           skid_valid_q;
	slsd_pkg::res_t main_q;
	slsd_pkg::res_t skid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_valid_q && !out_ready) begin
			if (in_valid && !skid_valid_q)
				skid_valid_q <= 1'b1;
		end else if (skid_valid_q) begin
			main_valid_q <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			main_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (main_valid_q && !out_ready) begin
			if (in_valid && !skid_valid_q)
				skid_q <= in_res;
		end else if (skid_valid_q) begin
			main_q <= skid_q;
		end else if (in_valid) begin
			main_q <= in_res;
		end
	end

endmodule
